/* src/sarm_pkg.sv */
package sarm_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int RAW_WIDTH_DEF = 16;
  localparam int REG_W         = 16;
  localparam int OUT_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int ANTI_SHIFT    = 4;
  localparam int N_AXES        = 3;
  localparam int N_ENT         = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_TGT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_Z = 2'd2;

endpackage

/* src/sarm_if.sv */
interface sarm_vec_if #(
  parameter int RAW_WIDTH = sarm_pkg::RAW_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [RAW_WIDTH-1:0] source_x;
  logic signed [RAW_WIDTH-1:0] source_y;
  logic signed [RAW_WIDTH-1:0] source_z;

  modport source (output valid, source_x, source_y, source_z, input ready);
  modport sink   (input valid, source_x, source_y, source_z, output ready);
endinterface

interface sarm_rot_if;
  logic                               valid;
  logic                               ready;
  logic signed [sarm_pkg::OUT_W-1:0]  rot_00;
  logic signed [sarm_pkg::OUT_W-1:0]  rot_01;
  logic signed [sarm_pkg::OUT_W-1:0]  rot_02;
  logic signed [sarm_pkg::OUT_W-1:0]  rot_10;
  logic signed [sarm_pkg::OUT_W-1:0]  rot_11;
  logic signed [sarm_pkg::OUT_W-1:0]  rot_12;
  logic signed [sarm_pkg::OUT_W-1:0]  rot_20;
  logic signed [sarm_pkg::OUT_W-1:0]  rot_21;
  logic signed [sarm_pkg::OUT_W-1:0]  rot_22;
  logic                               antiparallel;

  modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                  rot_20, rot_21, rot_22, antiparallel, input ready);
  modport sink   (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                  rot_20, rot_21, rot_22, antiparallel, output ready);
endinterface

/* src/sarm_sqrt.sv */
// pipelined integer square root, one result bit per stage
module sarm_sqrt #(
  parameter int IW = 32,
  parameter int SW = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [IW-1:0]          x_i,
  input  logic [SW-1:0]          side_i,
  output logic                   valid_o,
  output logic [(IW+IW%2)/2-1:0] root_o,
  output logic [SW-1:0]          side_o
);
  localparam int EW  = IW + IW % 2;
  localparam int RTW = EW / 2;
  localparam int RMW = RTW + 3;

  logic [EW-1:0]  x_s    [RTW+1];
  logic [RMW-1:0] rem_s  [RTW+1];
  logic [RTW-1:0] root_s [RTW+1];
  logic [SW-1:0]  side_s [RTW+1];
  logic           v_s    [RTW+1];

  assign x_s[0]    = EW'(x_i);
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign side_s[0] = side_i;
  assign v_s[0]    = valid_i;

  for (genvar k = 0; k < RTW; k++) begin : g_stage
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    logic           ge;

    always_comb begin
      rem_sh = {rem_s[k][RMW-3:0], x_s[k][EW-1:EW-2]};
      trial  = {1'b0, root_s[k], 2'b01};
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_s[k+1]    <= x_s[k] << 2;
        rem_s[k+1]  <= ge ? rem_sh - trial : rem_sh;
        root_s[k+1] <= {root_s[k][RTW-2:0], ge};
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign valid_o = v_s[RTW];
  assign root_o  = root_s[RTW];
  assign side_o  = side_s[RTW];

endmodule

/* src/sarm_div.sv */
// pipelined rounding divider, one quotient bit per stage, result saturated to +-1.0
module sarm_div #(
  parameter int LANES = 3,
  parameter int MW    = 16,
  parameter int DW    = 16,
  parameter int FB    = 14,
  parameter int SW    = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [LANES-1:0][MW-1:0]     mag_i,
  input  logic [LANES-1:0]             neg_i,
  input  logic [DW-1:0]                den_i,
  input  logic [SW-1:0]                side_i,
  output logic                         valid_o,
  output logic [LANES-1:0][FB+1:0]     q_o,
  output logic [SW-1:0]                side_o
);
  localparam int QW  = FB + 1;
  localparam int NW  = MW + FB + 1;
  localparam int CMW = (MW > DW) ? MW : DW;
  localparam logic [QW-1:0] ONE = QW'(1) << FB;

  logic [DW-1:0] rem_s  [QW+1][LANES];
  logic [QW-1:0] low_s  [QW+1][LANES];
  logic [QW-1:0] quo_s  [QW+1][LANES];
  logic          ovf_s  [QW+1][LANES];
  logic          neg_s  [QW+1][LANES];
  logic [DW-1:0] den_s  [QW+1];
  logic [SW-1:0] side_s [QW+1];
  logic          v_s    [QW+1];

  logic [NW-1:0] num    [LANES];
  logic [MW-1:0] hi     [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num[l] = (NW'(mag_i[l]) << FB) + NW'(den_i >> 1);
      hi[l]  = num[l][NW-1:QW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_s[0] <= 1'b0;
    end else if (en_i) begin
      v_s[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        rem_s[0][l] <= DW'(hi[l]);
        low_s[0][l] <= num[l][QW-1:0];
        quo_s[0][l] <= '0;
        ovf_s[0][l] <= CMW'(hi[l]) >= CMW'(den_i);
        neg_s[0][l] <= neg_i[l];
      end
      den_s[0]  <= den_i;
      side_s[0] <= side_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] rem_sh [LANES];
    logic [DW:0] rem_nx [LANES];
    logic        ge     [LANES];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        rem_sh[l] = {rem_s[k][l], low_s[k][l][QW-1]};
        ge[l]     = rem_sh[l] >= {1'b0, den_s[k]};
        rem_nx[l] = ge[l] ? rem_sh[l] - {1'b0, den_s[k]} : rem_sh[l];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < LANES; l++) begin
          rem_s[k+1][l] <= rem_nx[l][DW-1:0];
          low_s[k+1][l] <= low_s[k][l] << 1;
          quo_s[k+1][l] <= {quo_s[k][l][QW-2:0], ge[l]};
          ovf_s[k+1][l] <= ovf_s[k][l];
          neg_s[k+1][l] <= neg_s[k][l];
        end
        den_s[k+1]  <= den_s[k];
        side_s[k+1] <= side_s[k];
      end
    end
  end

  logic [QW-1:0]            qm   [LANES];
  logic [LANES-1:0][FB+1:0] q_d;
  logic [LANES-1:0][FB+1:0] q_q;
  logic [SW-1:0]            side_q;
  logic                     v_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qm[l]  = (ovf_s[QW][l] || quo_s[QW][l] > ONE) ? ONE : quo_s[QW][l];
      q_d[l] = neg_s[QW][l] ? -{1'b0, qm[l]} : {1'b0, qm[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= v_s[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q    <= q_d;
      side_q <= side_s[QW];
    end
  end

  assign valid_o = v_q;
  assign q_o     = q_q;
  assign side_o  = side_q;

endmodule

/* src/shortest_arc_rotation_matrix.sv */
// Throughput: one transaction per cycle while the output skid register is empty;
//   it holds one result, and the pipeline stalls while it is full. Both square
//   roots and both dividers are pipelined one bit per stage.
// Reset: asynchronous, active low; clears all valid bits and sets the target to +z.
module shortest_arc_rotation_matrix #(
  parameter int FRAC_BITS = sarm_pkg::FRAC_BITS_DEF,
  parameter int RAW_WIDTH = sarm_pkg::RAW_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sarm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sarm_pkg::REG_W-1:0]          cfg_data_i,
  sarm_vec_if.sink                            vec_i,
  sarm_rot_if.source                          rot_o
);
  localparam int F     = FRAC_BITS;
  localparam int RW    = RAW_WIDTH;
  localparam int RGW   = sarm_pkg::REG_W;
  localparam int OW    = sarm_pkg::OUT_W;
  localparam int NA    = sarm_pkg::N_AXES;
  localparam int NE    = sarm_pkg::N_ENT;
  localparam int SSW   = 2 * RW;
  localparam int FW    = F + 2;
  localparam int PW1   = FW + RGW;
  localparam int SUMW  = PW1 + 2;
  localparam int CW    = SUMW - F + 1;
  localparam int TW    = ((CW > FW) ? CW : FW) + 1;
  localparam int SIW   = TW + F;
  localparam int STW   = (SIW + SIW % 2) / 2;
  localparam int PQA   = 2 * FW;
  localparam int PQB   = FW + STW + 1;
  localparam int PQW   = (PQA > PQB) ? PQA : PQB;
  localparam int MSW   = PQW + 3;
  localparam logic [STW-1:0] ANTI_LIM = STW'(1) << (F - sarm_pkg::ANTI_SHIFT);

  // configuration
  logic signed [RGW-1:0] tgt_q [NA];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q[0] <= '0;
      tgt_q[1] <= '0;
      tgt_q[2] <= RGW'(64'd1 << F);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sarm_pkg::CFG_TGT_X: tgt_q[0] <= cfg_data_i;
        sarm_pkg::CFG_TGT_Y: tgt_q[1] <= cfg_data_i;
        sarm_pkg::CFG_TGT_Z: tgt_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_q;
  assign en          = !skid_q;
  assign vec_i.ready = en;

  function automatic logic signed [CW-1:0] rnd_c(logic signed [SUMW-1:0] v);
    logic [SUMW-1:0] mag;
    logic [SUMW-1:0] rm;
    mag = v[SUMW-1] ? -v : v;
    rm  = (mag + (SUMW'(1) << (F - 1))) >> F;
    return v[SUMW-1] ? -CW'(rm) : CW'(rm);
  endfunction

  function automatic logic [OW-1:0] fin(logic signed [MSW-1:0] v);
    logic [MSW-1:0]        mag;
    logic [MSW-1:0]        rm;
    logic signed [MSW-1:0] r;
    logic signed [MSW-1:0] one;
    mag = v[MSW-1] ? -v : v;
    rm  = (mag + (MSW'(1) << (F - 1))) >> F;
    r   = v[MSW-1] ? -$signed(rm) : $signed(rm);
    one = MSW'(1) << F;
    if (r > one) begin
      r = one;
    end else if (r < -one) begin
      r = -one;
    end
    return r[OW-1:0];
  endfunction

  // stage A: squares
  logic signed [RW-1:0] raw_in [NA];
  logic [RW-1:0]        mag_in [NA];
  logic signed [RW-1:0] raw_a_q [NA];
  logic [SSW-1:0]       sq_a_q  [NA];
  logic                 v_a_q;

  assign raw_in[0] = RW'(vec_i.source_x);
  assign raw_in[1] = RW'(vec_i.source_y);
  assign raw_in[2] = RW'(vec_i.source_z);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      mag_in[i] = raw_in[i][RW-1] ? -raw_in[i] : raw_in[i];
    end
  end

  // stage B: sum of squares
  logic [SSW-1:0]       sumsq_b_q;
  logic signed [RW-1:0] raw_b_q [NA];
  logic                 v_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
    end else if (en) begin
      v_a_q <= vec_i.valid;
      v_b_q <= v_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        raw_a_q[i] <= raw_in[i];
        sq_a_q[i]  <= SSW'(mag_in[i]) * SSW'(mag_in[i]);
        raw_b_q[i] <= raw_a_q[i];
      end
      sumsq_b_q <= sq_a_q[0] + sq_a_q[1] + sq_a_q[2];
    end
  end

  // vector length
  logic              v_l;
  logic [RW-1:0]     len_l;
  logic [3*RW-1:0]   raw_l;

  sarm_sqrt #(.IW(SSW), .SW(3 * RW)) u_len (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_b_q),
    .x_i     (sumsq_b_q),
    .side_i  ({raw_b_q[0], raw_b_q[1], raw_b_q[2]}),
    .valid_o (v_l),
    .root_o  (len_l),
    .side_o  (raw_l)
  );

  // normalize
  logic [NA-1:0][RW-1:0] nmag;
  logic [NA-1:0]         nneg;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      nneg[i] = raw_l[(NA-i)*RW-1];
      nmag[i] = nneg[i] ? -raw_l[(NA-i)*RW-1 -: RW] : raw_l[(NA-i)*RW-1 -: RW];
    end
  end

  logic                  v_n;
  logic [NA-1:0][FW-1:0] f_n;
  logic                  lz_n;

  sarm_div #(.LANES(NA), .MW(RW), .DW(RW), .FB(F), .SW(1)) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_l),
    .mag_i   (nmag),
    .neg_i   (nneg),
    .den_i   (len_l),
    .side_i  (len_l == '0),
    .valid_o (v_n),
    .q_o     (f_n),
    .side_o  (lz_n)
  );

  // stage P: dot and cross products
  logic signed [FW-1:0]  f [NA];
  logic signed [PW1-1:0] p_q [NE];
  logic                  v_p_q;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      f[i] = lz_n ? '0 : $signed(f_n[i]);
    end
  end

  // stage R: round dot and cross
  logic signed [CW-1:0] c_r_q;
  logic signed [CW-1:0] cr_r_q [NA];
  logic                 v_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_p_q <= 1'b0;
      v_r_q <= 1'b0;
    end else if (en) begin
      v_p_q <= v_n;
      v_r_q <= v_p_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= PW1'(f[0]) * PW1'(tgt_q[0]);
      p_q[1] <= PW1'(f[1]) * PW1'(tgt_q[1]);
      p_q[2] <= PW1'(f[2]) * PW1'(tgt_q[2]);
      p_q[3] <= PW1'(f[1]) * PW1'(tgt_q[2]);
      p_q[4] <= PW1'(f[2]) * PW1'(tgt_q[1]);
      p_q[5] <= PW1'(f[2]) * PW1'(tgt_q[0]);
      p_q[6] <= PW1'(f[0]) * PW1'(tgt_q[2]);
      p_q[7] <= PW1'(f[0]) * PW1'(tgt_q[1]);
      p_q[8] <= PW1'(f[1]) * PW1'(tgt_q[0]);
      c_r_q     <= rnd_c(SUMW'(p_q[0]) + SUMW'(p_q[1]) + SUMW'(p_q[2]));
      cr_r_q[0] <= rnd_c(SUMW'(p_q[3]) - SUMW'(p_q[4]));
      cr_r_q[1] <= rnd_c(SUMW'(p_q[5]) - SUMW'(p_q[6]));
      cr_r_q[2] <= rnd_c(SUMW'(p_q[7]) - SUMW'(p_q[8]));
    end
  end

  // s = sqrt(2(1+c)) in fixed point
  logic signed [TW-1:0] t_r;
  logic [TW-2:0]        tc_r;
  logic [SIW-1:0]       sin_r;

  always_comb begin
    t_r   = $signed(TW'(1) << F) + TW'(c_r_q);
    tc_r  = t_r[TW-1] ? '0 : t_r[TW-2:0];
    sin_r = {tc_r, {(F + 1){1'b0}}};
  end

  logic            v_s2;
  logic [STW-1:0]  s_s2;
  logic [3*CW-1:0] cr_s2;

  sarm_sqrt #(.IW(SIW), .SW(3 * CW)) u_arc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_r_q),
    .x_i     (sin_r),
    .side_i  ({cr_r_q[0], cr_r_q[1], cr_r_q[2]}),
    .valid_o (v_s2),
    .root_o  (s_s2),
    .side_o  (cr_s2)
  );

  // quaternion vector part
  logic [NA-1:0][CW-1:0] qmag;
  logic [NA-1:0]         qneg;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      qneg[i] = cr_s2[(NA-i)*CW-1];
      qmag[i] = qneg[i] ? -cr_s2[(NA-i)*CW-1 -: CW] : cr_s2[(NA-i)*CW-1 -: CW];
    end
  end

  logic                  v_q;
  logic [NA-1:0][FW-1:0] q_q;
  logic [STW-1:0]        s_q;

  sarm_div #(.LANES(NA), .MW(CW), .DW(STW), .FB(F), .SW(STW)) u_quat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_s2),
    .mag_i   (qmag),
    .neg_i   (qneg),
    .den_i   (s_s2),
    .side_i  (s_s2),
    .valid_o (v_q),
    .q_o     (q_q),
    .side_o  (s_q)
  );

  // stage Q: quaternion products
  logic signed [FW-1:0]  qx, qy, qz;
  logic [STW:0]          s_inc;
  logic signed [STW:0]   qw;
  logic signed [PQW-1:0] pq_q [NE];
  logic                  anti_q_q;
  logic                  v_qq_q;

  always_comb begin
    qx    = $signed(q_q[0]);
    qy    = $signed(q_q[1]);
    qz    = $signed(q_q[2]);
    s_inc = {1'b0, s_q} + 1'b1;
    qw    = $signed({1'b0, s_inc[STW:1]});
  end

  // stage M: matrix sums
  logic signed [MSW-1:0] m_q [NE];
  logic signed [MSW-1:0] one2;
  logic                  anti_m_q;
  logic                  v_m_q;

  assign one2 = MSW'(1) << (2 * F);

  // stage O: round, saturate, antiparallel select
  logic [OW-1:0] rot_o_q [NE];
  logic          anti_o_q;
  logic          v_o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_qq_q <= 1'b0;
      v_m_q  <= 1'b0;
      v_o_q  <= 1'b0;
    end else if (en) begin
      v_qq_q <= v_q;
      v_m_q  <= v_qq_q;
      v_o_q  <= v_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pq_q[0]  <= PQW'(qx) * PQW'(qx);
      pq_q[1]  <= PQW'(qy) * PQW'(qy);
      pq_q[2]  <= PQW'(qz) * PQW'(qz);
      pq_q[3]  <= PQW'(qx) * PQW'(qy);
      pq_q[4]  <= PQW'(qx) * PQW'(qz);
      pq_q[5]  <= PQW'(qy) * PQW'(qz);
      pq_q[6]  <= PQW'(qx) * PQW'(qw);
      pq_q[7]  <= PQW'(qy) * PQW'(qw);
      pq_q[8]  <= PQW'(qz) * PQW'(qw);
      anti_q_q <= s_q < ANTI_LIM;

      m_q[0] <= one2 - (MSW'(pq_q[1]) <<< 1) - (MSW'(pq_q[2]) <<< 1);
      m_q[1] <= (MSW'(pq_q[3]) <<< 1) - (MSW'(pq_q[8]) <<< 1);
      m_q[2] <= (MSW'(pq_q[4]) <<< 1) + (MSW'(pq_q[7]) <<< 1);
      m_q[3] <= (MSW'(pq_q[3]) <<< 1) + (MSW'(pq_q[8]) <<< 1);
      m_q[4] <= one2 - (MSW'(pq_q[0]) <<< 1) - (MSW'(pq_q[2]) <<< 1);
      m_q[5] <= (MSW'(pq_q[5]) <<< 1) - (MSW'(pq_q[6]) <<< 1);
      m_q[6] <= (MSW'(pq_q[4]) <<< 1) - (MSW'(pq_q[7]) <<< 1);
      m_q[7] <= (MSW'(pq_q[5]) <<< 1) + (MSW'(pq_q[6]) <<< 1);
      m_q[8] <= one2 - (MSW'(pq_q[0]) <<< 1) - (MSW'(pq_q[1]) <<< 1);
      anti_m_q <= anti_q_q;

      for (int i = 0; i < NE; i++) begin
        if (anti_m_q) begin
          rot_o_q[i] <= (i % 4 == 0) ? OW'(64'd1 << F) : '0;
        end else begin
          rot_o_q[i] <= fin(m_q[i]);
        end
      end
      anti_o_q <= anti_m_q;
    end
  end

  // output skid register
  logic [OW-1:0] rot_s_q [NE];
  logic          anti_s_q;
  logic [OW-1:0] rot_out [NE];
  logic          anti_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_q <= 1'b0;
    end else if (skid_q) begin
      skid_q <= !rot_o.ready;
    end else begin
      skid_q <= v_o_q && !rot_o.ready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_q) begin
      rot_s_q  <= rot_o_q;
      anti_s_q <= anti_o_q;
    end
  end

  always_comb begin
    for (int i = 0; i < NE; i++) begin
      rot_out[i] = skid_q ? rot_s_q[i] : rot_o_q[i];
    end
    anti_out = skid_q ? anti_s_q : anti_o_q;
  end

  assign rot_o.valid        = skid_q || v_o_q;
  assign rot_o.rot_00       = rot_out[0];
  assign rot_o.rot_01       = rot_out[1];
  assign rot_o.rot_02       = rot_out[2];
  assign rot_o.rot_10       = rot_out[3];
  assign rot_o.rot_11       = rot_out[4];
  assign rot_o.rot_12       = rot_out[5];
  assign rot_o.rot_20       = rot_out[6];
  assign rot_o.rot_21       = rot_out[7];
  assign rot_o.rot_22       = rot_out[8];
  assign rot_o.antiparallel = anti_out;

endmodule
